/* src/wsp_pkg.sv */
// wsp_pkg: shared types and constants for the wheel speed tachometer.
// No dependencies; used by wsp_addsub and wheel_speed_from_pulses_core.
package wsp_pkg;

    localparam int POS_W      = 13;
    localparam int DIAM_W     = 12;
    localparam int PERIOD_W   = 16;
    localparam int SPEED_W    = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PI_W       = 15;
    localparam int QUOT_W     = 16;
    // positions * elapsed * 10
    localparam int DEN_W      = POS_W + TIME_W + 4;

    localparam logic [PI_W-1:0] PI_NUM = 15'd31415;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [POS_W-1:0]    RST_POSITIONS = 13'd20;
    localparam logic [DIAM_W-1:0]   RST_DIAMETER  = 12'd500;
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = 16'd100;
    localparam logic [SPEED_W-1:0]  RST_LIMIT     = 16'd6944;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POSITIONS = 2'd0,
        CFG_DIAMETER  = 2'd1,
        CFG_PERIOD    = 2'd2,
        CFG_LIMIT     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic sub;
    } t_alu_ctl;

endpackage

/* src/wsp_addsub.sv */
// wsp_addsub: shared wide adder/subtractor with carry out.
// Depends on wsp_pkg (t_alu_ctl).
module wsp_addsub import wsp_pkg::*; #(
    parameter int W = 66
) (
    input  t_alu_ctl       i_ctl,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [W-1:0]   o_sum,
    output logic           o_carry
);

    logic [W:0] c_full;

    // carry high on subtract means no borrow (a >= b)
    assign c_full  = {1'b0, i_a} + {1'b0, (i_ctl.sub ? ~i_b : i_b)} + {{W{1'b0}}, i_ctl.sub};
    assign o_sum   = c_full[W-1:0];
    assign o_carry = c_full[W];

endmodule

/* src/wheel_speed_from_pulses_core.sv */
// wheel_speed_from_pulses_core: encoder pulse counting tachometer, top level.
// Depends on wsp_pkg and wsp_addsub.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+----------------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_opcode, i_now_ms
//  out     | o_out_valid  | i_out_ready  | o_speed_mm_s, o_sensor_ok, o_pulse_count,
//          |              |              | o_evaluated
//  cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Pulse beats and early evaluate beats: result one cycle after acceptance.
// Due evaluate beats: two multiplies, x10, 15-step shift-add by pi, saturation check and
// 16-step restoring division; the division is skipped when saturated or when m1 is zero.
// The x10, shift-add, saturation check and division run through the one shared adder/subtractor.
// Synchronous active-low reset; no input taken while busy or while a result waits
// unless it is taken in the same cycle. Config is always ready.
module wheel_speed_from_pulses_core import wsp_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SPEED_W-1:0]    o_speed_mm_s,
    output logic                  o_sensor_ok,
    output logic [15:0]           o_pulse_count,
    output logic                  o_evaluated,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_W  = COUNT_WIDTH + PI_W + DIAM_W;
    localparam int SH_W   = DEN_W + QUOT_W;
    localparam int ACC_W  = ((NUM_W > SH_W) ? NUM_W : SH_W) + 1;
    localparam int M1_W   = COUNT_WIDTH + DIAM_W;
    localparam int STEP_W = $clog2(QUOT_W);

    typedef enum logic [2:0] {
        S_IDLE, S_MULA, S_MULB, S_DEN, S_PIMUL, S_SAT, S_DIV, S_FIN
    } t_state;

    t_state                   r_state;
    logic [COUNT_WIDTH-1:0]   r_cnt;
    logic [TIME_W-1:0]        r_last;
    logic [TIME_W-1:0]        r_now;
    logic [TIME_W-1:0]        r_elapsed;
    logic [SPEED_W-1:0]       r_speed;
    logic                     r_ok;
    logic [POS_W-1:0]         r_pos;
    logic [DIAM_W-1:0]        r_diam;
    logic [PERIOD_W-1:0]      r_period;
    logic [SPEED_W-1:0]       r_limit;
    logic [M1_W-1:0]          r_m1;
    logic [DEN_W-1:0]         r_den;
    logic [ACC_W-1:0]         r_acc;
    logic [QUOT_W-1:0]        r_quot;
    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    logic [SPEED_W-1:0]       r_out_speed;
    logic                     r_out_ok;
    logic [15:0]              r_out_count;
    logic                     r_out_eval;

    logic                     c_in_fire;
    logic                     c_in_result;
    logic [TIME_W-1:0]        c_elapsed;
    logic                     c_due;
    logic [COUNT_WIDTH-1:0]   n_cnt;
    logic                     n_over;
    t_alu_ctl                 c_alu_ctl;
    logic [ACC_W-1:0]         c_alu_a;
    logic [ACC_W-1:0]         c_alu_b;
    logic [ACC_W-1:0]         c_alu_sum;
    logic                     c_alu_carry;

    function automatic logic [15:0] cnt_sat(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] hi;
        hi = v >> 16;
        cnt_sat = (|hi) ? 16'hFFFF : 16'(v);
    endfunction

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign c_in_fire   = i_in_valid && o_in_ready;
    assign c_elapsed   = i_now_ms - r_last;
    assign c_due       = c_elapsed >= TIME_W'(r_period);
    // beat answered straight from idle: pulse or early evaluate
    assign c_in_result = c_in_fire && ((i_opcode == OP_PULSE) || !c_due);
    assign n_cnt       = (r_cnt == '1) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
    assign n_over      = (r_quot > r_limit) || ((r_quot == r_limit) && (r_acc != '0));

    always_comb begin
        c_alu_ctl.sub = 1'b0;
        c_alu_a       = '0;
        c_alu_b       = '0;
        case (r_state)
            S_DEN: begin
                c_alu_a = ACC_W'(r_den) << 3;
                c_alu_b = ACC_W'(r_den) << 1;
            end
            S_PIMUL: begin
                c_alu_a = r_acc;
                c_alu_b = PI_NUM[r_step] ? (ACC_W'(r_m1) << r_step) : '0;
            end
            S_SAT: begin
                c_alu_ctl.sub = 1'b1;
                c_alu_a       = r_acc;
                c_alu_b       = ACC_W'(r_den) << QUOT_W;
            end
            S_DIV: begin
                c_alu_ctl.sub = 1'b1;
                c_alu_a       = r_acc;
                c_alu_b       = ACC_W'(r_den) << r_step;
            end
            default: begin
                c_alu_ctl.sub = 1'b0;
            end
        endcase
    end

    wsp_addsub #(.W(ACC_W)) u_alu (
        .i_ctl   (c_alu_ctl),
        .i_a     (c_alu_a),
        .i_b     (c_alu_b),
        .o_sum   (c_alu_sum),
        .o_carry (c_alu_carry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last      <= '0;
            r_speed     <= '0;
            r_ok        <= 1'b1;
            r_pos       <= RST_POSITIONS;
            r_diam      <= RST_DIAMETER;
            r_period    <= RST_PERIOD;
            r_limit     <= RST_LIMIT;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_POSITIONS: r_pos    <= i_cfg_data[POS_W-1:0];
                    CFG_DIAMETER:  r_diam   <= i_cfg_data[DIAM_W-1:0];
                    CFG_PERIOD:    r_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_LIMIT:     r_limit  <= i_cfg_data[SPEED_W-1:0];
                    default:       r_limit  <= r_limit;
                endcase
            end

            if (r_out_valid && i_out_ready && !c_in_result) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (c_in_fire) begin
                        if (i_opcode == OP_PULSE) begin
                            r_cnt       <= n_cnt;
                            r_out_valid <= 1'b1;
                            r_out_speed <= r_speed;
                            r_out_ok    <= r_ok;
                            r_out_count <= cnt_sat(n_cnt);
                            r_out_eval  <= 1'b0;
                        end else if (c_due) begin
                            r_now     <= i_now_ms;
                            r_elapsed <= c_elapsed;
                            r_state   <= S_MULA;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_speed <= r_speed;
                            r_out_ok    <= r_ok;
                            r_out_count <= cnt_sat(r_cnt);
                            r_out_eval  <= 1'b0;
                        end
                    end
                end
                S_MULA: begin
                    r_m1    <= M1_W'(r_cnt) * M1_W'(r_diam);
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_den   <= DEN_W'(r_pos) * DEN_W'(r_elapsed);
                    r_acc   <= '0;
                    r_step  <= '0;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den   <= c_alu_sum[DEN_W-1:0];
                    r_state <= S_PIMUL;
                end
                S_PIMUL: begin
                    r_acc <= c_alu_sum;
                    if (r_step == STEP_W'(PI_W - 1)) begin
                        r_state <= S_SAT;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_SAT: begin
                    if (r_m1 == '0) begin
                        r_acc   <= '0;
                        r_quot  <= '0;
                        r_state <= S_FIN;
                    end else if (c_alu_carry) begin
                        // quotient past 16 bits, or zero divisor
                        r_quot  <= '1;
                        r_state <= S_FIN;
                    end else begin
                        r_quot  <= '0;
                        r_step  <= STEP_W'(QUOT_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (c_alu_carry) begin
                        r_acc          <= c_alu_sum;
                        r_quot[r_step] <= 1'b1;
                    end
                    if (r_step == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_FIN: begin
                    r_speed     <= r_quot;
                    r_ok        <= !n_over;
                    r_last      <= r_now;
                    r_cnt       <= '0;
                    r_out_valid <= 1'b1;
                    r_out_speed <= r_quot;
                    r_out_ok    <= !n_over;
                    r_out_count <= '0;
                    r_out_eval  <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_speed_mm_s  = r_out_speed;
    assign o_sensor_ok   = r_out_ok;
    assign o_pulse_count = r_out_count;
    assign o_evaluated   = r_out_eval;

    a_eval_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evaluated) |-> (o_pulse_count == '0))
        else $error("evaluated beat with non-zero pulse count");

    a_pulse_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_in_fire && (i_opcode == OP_PULSE)) |=> (o_out_valid && !o_evaluated))
        else $error("pulse beat did not produce a result next cycle");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while sequencer busy");

    a_fin_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> ((r_state == S_IDLE) && r_out_valid && (r_cnt == '0)))
        else $error("evaluation did not complete cleanly");

endmodule

/* tb/sv/wheel_speed_from_pulses_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wheel_speed_from_pulses_core: random bursts of pulse and
// evaluate beats under several register settings, checked against an in-bench predictor.
// Depends on wsp_pkg and the RTL of wheel_speed_from_pulses_core.
module wheel_speed_from_pulses_core_tb;
    import wsp_pkg::*;

    localparam int          PI_NUMER    = 31415;
    localparam int          PI_SCALE    = 10;
    localparam int          TAIL_CYCLES = 40;
    // worst case: ~1500 beats, each with an input gap, a busy evaluation and a receiver stall
    localparam longint      CYCLE_LIMIT = 1_000_000;
    localparam logic [15:0] SPEED_MAX   = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [15:0] speed;
        logic        ok;
        logic [15:0] count;
        logic        evaluated;
    } t_reading;

    class speed_scoreboard;
        logic [12:0] positions;
        logic [11:0] diameter;
        logic [15:0] period;
        logic [15:0] limit;
        logic [15:0] count;
        logic [31:0] last_ms;
        logic [15:0] speed;
        logic        ok;
        t_reading    expected_q[$];
        int          n_errors;
        int          n_items;
        int          n_evals;
        int          n_early;
        int          n_sat;
        int          n_faults;

        function new();
            positions = 13'd20;
            diameter  = 12'd500;
            period    = 16'd100;
            limit     = 16'd6944;
            count     = '0;
            last_ms   = '0;
            speed     = '0;
            ok        = 1'b1;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_POSITIONS: positions = data[12:0];
                CFG_DIAMETER:  diameter  = data[11:0];
                CFG_PERIOD:    period    = data;
                CFG_LIMIT:     limit     = data;
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic [31:0] now_ms);
            logic [31:0]     elapsed;
            longint unsigned num;
            longint unsigned den;
            longint unsigned quot;
            longint unsigned rem;
            logic            over;
            t_reading        exp;
            exp.evaluated = 1'b0;
            n_items++;
            if (op == OP_PULSE) begin
                if (count != COUNT_MAX) count++;
            end else begin
                elapsed = now_ms - last_ms;
                if (elapsed >= 32'(period)) begin
                    num = 64'(count);
                    num = num * PI_NUMER * diameter;
                    den = 64'(positions);
                    den = den * elapsed * PI_SCALE;
                    if (num == 0) begin
                        speed = '0;
                        over  = 1'b0;
                    end else if (den == 0) begin
                        speed = SPEED_MAX;
                        over  = 1'b1;
                    end else begin
                        quot  = num / den;
                        rem   = num % den;
                        speed = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[15:0];
                        over  = (quot > limit) || (quot == limit && rem != 0);
                    end
                    ok            = ~over;
                    last_ms       = now_ms;
                    count         = '0;
                    exp.evaluated = 1'b1;
                    n_evals++;
                    if (speed == SPEED_MAX) n_sat++;
                    if (!ok) n_faults++;
                end else begin
                    n_early++;
                end
            end
            exp.speed = speed;
            exp.ok    = ok;
            exp.count = count;
            expected_q.push_back(exp);
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (exp !== act) begin
                n_errors++;
                if (n_errors <= 100)
                    $display("%0t: %s expected %0d got %0d", $time, name, exp, act);
            end
        endfunction

        function void check_result(t_reading got);
            t_reading exp;
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result beat, speed %0d ok %0d count %0d eval %0d",
                         $time, got.speed, got.ok, got.count, got.evaluated);
            end else begin
                exp = expected_q.pop_front();
                compare_field("speed_mm_s", exp.speed, got.speed);
                compare_field("sensor_ok", 16'(exp.ok), 16'(got.ok));
                compare_field("pulse_count", exp.count, got.count);
                compare_field("evaluated", 16'(exp.evaluated), 16'(got.evaluated));
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_opcode = OP_PULSE;
    logic [TIME_W-1:0]     in_now    = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_idx              cfg_index = CFG_POSITIONS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    wire                   in_ready;
    wire                   out_valid;
    wire  [SPEED_W-1:0]    speed_out;
    wire                   ok_out;
    wire  [15:0]           count_out;
    wire                   eval_out;
    wire                   cfg_ready;

    speed_scoreboard sb = new();
    t_reading        out_beat;
    longint          n_cycles   = 0;
    int              n_sent     = 0;
    int              n_results  = 0;
    int              n_settings = 0;
    int              burst_left = 0;
    bit              gaps_on    = 1'b1;
    int              stall_mode = 0;
    int              stall_left = 0;
    logic [31:0]     mark_ms    = '0;

    wheel_speed_from_pulses_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (in_opcode),
        .i_now_ms      (in_now),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_speed_mm_s  (speed_out),
        .o_sensor_ok   (ok_out),
        .o_pulse_count (count_out),
        .o_evaluated   (eval_out),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    // receiver: spells of always-ready, coin-flip and mostly-stalled
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0, 1:    out_ready <= 1'b1;
            2:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", n_cycles,
                     n_sent - n_results);
            $display("FAILED: results differ");
            $finish;
        end else if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready) sb.note_item(in_opcode, in_now);
            if (out_valid && out_ready) begin
                out_beat.speed     = speed_out;
                out_beat.ok        = ok_out;
                out_beat.count     = count_out;
                out_beat.evaluated = eval_out;
                sb.check_result(out_beat);
                n_results++;
            end
        end
    end

    task automatic send_item(input logic op, input logic [31:0] now_ms);
        if (gaps_on && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_now    <= now_ms;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_sent++;
    endtask

    task automatic send_pulses(input int n);
        for (int i = 0; i < n; i++) send_item(OP_PULSE, $urandom());
    endtask

    // mark_ms follows the time of the last due evaluation
    task automatic send_eval(input logic [31:0] now_ms);
        logic [31:0] elapsed;
        elapsed = now_ms - mark_ms;
        if (elapsed >= 32'(sb.period)) mark_ms = now_ms;
        send_item(OP_EVAL, now_ms);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (n_results < n_sent) @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] pos, input logic [15:0] diam,
                               input logic [15:0] period, input logic [15:0] lim);
        logic [15:0] vals [4];
        t_cfg_idx    idx;
        vals[0] = pos;
        vals[1] = diam;
        vals[2] = period;
        vals[3] = lim;
        idx     = CFG_POSITIONS;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int n_items);
        int          sent;
        int          n_p;
        int          p;
        logic [31:0] el;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: n_p = $urandom_range(0, 4);
                4, 5, 6, 7: n_p = $urandom_range(5, 40);
                8:          n_p = $urandom_range(41, 250);
                default:    n_p = 0;
            endcase
            if (n_p > n_items - sent) n_p = n_items - sent;
            send_pulses(n_p);
            sent += n_p;
            p = int'(sb.period);
            case ($urandom_range(0, 19))
                0, 1, 2: el = (p == 0) ? '0 : $urandom_range(0, p - 1);
                3, 4:    el = p;
                5:       el = $urandom();
                default: el = p + $urandom_range(0, p / 2 + 20);
            endcase
            send_eval(mark_ms + el);
            sent++;
        end
    endtask

    initial begin
        logic [15:0] rnd_cfg [8][4];
        rnd_cfg[0] = '{16'd20, 16'd500, 16'd100, 16'd6944};
        rnd_cfg[1] = '{16'd4096, 16'd4000, 16'd65535, 16'd65535};
        rnd_cfg[2] = '{16'd1, 16'd1, 16'd1, 16'd0};
        rnd_cfg[3] = '{16'd1, 16'd4000, 16'd1, 16'd65535};
        // upper bits beyond the register widths: positions 8191, diameter 0
        rnd_cfg[4] = '{16'hFFFF, 16'hF000, 16'd0, 16'd100};
        for (int k = 5; k < 8; k++) begin
            rnd_cfg[k][0] = 16'($urandom_range(1, 4096));
            rnd_cfg[k][1] = 16'($urandom_range(1, 4000));
            rnd_cfg[k][2] = 16'($urandom_range(1, 300));
            rnd_cfg[k][3] = 16'($urandom_range(0, 65535));
        end
        rnd_cfg[7][1] = 16'($urandom());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: early, due, over limit, idle, wrap of the ms time
        send_eval(32'd0);
        send_pulses(1);
        send_eval(32'd99);
        send_eval(32'd100);
        send_pulses(9);
        send_eval(mark_ms + 32'd100);
        send_eval(mark_ms + 32'd100);
        send_eval(32'hFFFF_FFF0);
        send_eval(mark_ms + 32'd99);
        send_eval(mark_ms + 32'd100);

        // back-to-back pulse run, then evaluate into speed saturation
        gaps_on = 1'b0;
        send_pulses(100);
        gaps_on = 1'b1;
        send_eval(mark_ms + 32'd100);
        send_eval(32'hFFFF_FFFF);
        send_eval(32'd0);

        // speed exactly on the limit, and just above it by a fraction
        drain();
        load_config(16'd1, 16'd10, 16'd1, 16'd31415);
        send_pulses(1);
        send_eval(mark_ms + 32'd1);
        drain();
        load_config(16'd1, 16'd10, 16'd1, 16'd15707);
        send_pulses(1);
        send_eval(mark_ms + 32'd2);
        send_pulses(2);
        send_eval(mark_ms + 32'd2);

        // zero positions and zero period
        drain();
        load_config(16'h2000, 16'd500, 16'd0, 16'd0);
        send_eval(mark_ms);
        send_pulses(1);
        send_eval(mark_ms);
        send_pulses(2);
        send_eval(mark_ms + 32'd5);

        for (int k = 0; k < 8; k++) begin
            drain();
            load_config(rnd_cfg[k][0], rnd_cfg[k][1], rnd_cfg[k][2], rnd_cfg[k][3]);
            run_random(170);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0) begin
            sb.n_errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
        end
        $display("Run covered %0d input beats over %0d register settings in %0d cycles.",
                 sb.n_items, n_settings, n_cycles);
        $display("Evaluations %0d (early %0d, saturated %0d, over limit %0d), mismatches %0d.",
                 sb.n_evals, sb.n_early, sb.n_sat, sb.n_faults, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
